### sv/macd_indicator_filter_core_defines.svh
// ----------------------------------------------------------------------------
// macd indicator filter assertion macros
// shared property wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef MACD_INDICATOR_FILTER_CORE_DEFINES_SVH
`define MACD_INDICATOR_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MIF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define MIF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MIF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define MIF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/mif_pkg.sv
// ----------------------------------------------------------------------------
// mif_pkg
// shared types, constants and helpers of the macd indicator filter
// ----------------------------------------------------------------------------
package mif_pkg;

    // field widths
    localparam int PRICE_W  = 32;
    localparam int SIG_W    = 33;
    localparam int HIST_W   = 35;
    localparam int PER_W    = 8;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_TDATA_W = 168;

    // numerator of one average update: 33b signed times 9b plus 2*x
    localparam int NUM_W    = 42;
    localparam int MAG_W    = NUM_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int DVS_W    = PER_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_PERIOD = 2'd2;

    // register reset values
    localparam logic [PER_W-1:0] FAST_PERIOD_RST   = 8'd12;
    localparam logic [PER_W-1:0] SLOW_PERIOD_RST   = 8'd26;
    localparam logic [PER_W-1:0] SIGNAL_PERIOD_RST = 8'd9;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_WB,
        ST_OUT
    } t_state;

    // which average is being updated
    typedef enum logic [1:0] {
        OP_FAST,
        OP_SLOW,
        OP_SIG
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic load;
        logic step;
        logic wb;
        logic out_load;
        t_op  op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic restart;
        logic out_busy;
    } t_sts;

    // a period of zero behaves as one
    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
        eff_period = (p == '0) ? PER_W'(1) : p;
    endfunction

endpackage

### sv/mif_ctrl.sv
// ----------------------------------------------------------------------------
// mif_ctrl
// sequencer: accept, three average updates through the shared divider (skipped on restart), output
// ----------------------------------------------------------------------------
module mif_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  mif_pkg::t_sts     i_sts,
    output mif_pkg::t_cmd     o_cmd
);

    mif_pkg::t_state r_state, n_state;
    mif_pkg::t_op    r_op, n_op;
    logic [mif_pkg::STEP_W-1:0] r_step, n_step;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mif_pkg::ST_IDLE;
            r_op    <= mif_pkg::OP_FAST;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_step    = r_step;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        o_cmd.op  = r_op;
        case (r_state)
            mif_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = mif_pkg::ST_START;
                end
            end
            mif_pkg::ST_START: begin
                n_op = mif_pkg::OP_FAST;
                if (i_sts.restart) begin
                    n_state = mif_pkg::ST_OUT;
                end else begin
                    n_state = mif_pkg::ST_MUL;
                end
            end
            mif_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = mif_pkg::ST_LOAD;
            end
            mif_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = mif_pkg::ST_DIV;
            end
            mif_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                if (r_step == mif_pkg::STEP_W'(mif_pkg::DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = mif_pkg::ST_WB;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            mif_pkg::ST_WB: begin
                o_cmd.wb = 1'b1;
                case (r_op)
                    mif_pkg::OP_FAST: begin
                        n_op    = mif_pkg::OP_SLOW;
                        n_state = mif_pkg::ST_MUL;
                    end
                    mif_pkg::OP_SLOW: begin
                        n_op    = mif_pkg::OP_SIG;
                        n_state = mif_pkg::ST_MUL;
                    end
                    default: begin
                        n_state = mif_pkg::ST_OUT;
                    end
                endcase
            end
            mif_pkg::ST_OUT: begin
                // wait until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mif_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mif_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/mif_datapath.sv
// ----------------------------------------------------------------------------
// mif_datapath
// average state, shared multiply-add, restoring divider and output register
// ----------------------------------------------------------------------------
module mif_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mif_pkg::t_cmd                    i_cmd,
    output mif_pkg::t_sts                    o_sts,
    // configuration writes
    input  logic                             i_cfg_wr,
    input  logic [mif_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mif_pkg::PER_W-1:0]        i_cfg_data,
    // input payload: [31:0] price
    input  logic [mif_pkg::PRICE_W-1:0]      i_price,
    // input flag: restart
    input  logic                             i_restart,
    // output channel
    input  logic                             i_m_ready,
    output logic                             o_m_valid,
    output logic [mif_pkg::OUT_TDATA_W-1:0]  o_m_data,
    output logic                             o_m_user
);

    // configuration
    logic [mif_pkg::PER_W-1:0] r_fast_per, r_slow_per, r_sig_per;

    // series state
    logic [mif_pkg::PRICE_W-1:0]      r_ema_fast, r_ema_slow, r_price;
    logic signed [mif_pkg::SIG_W-1:0] r_ema_sig, r_dif;
    logic [mif_pkg::CNT_W-1:0]        r_count;
    logic                             r_restart;

    // arithmetic
    logic signed [mif_pkg::NUM_W-1:0] r_num;
    logic [mif_pkg::MAG_W-1:0]        r_quo;
    logic [mif_pkg::PER_W-1:0]        r_rem;
    logic                             r_neg;

    // output register
    logic                             r_m_valid;
    logic [mif_pkg::OUT_TDATA_W-1:0]  r_m_data;
    logic                             r_m_user;

    logic signed [mif_pkg::SIG_W-1:0] w_old, w_x;
    logic [mif_pkg::PER_W-1:0]        w_per, w_pe, w_nm1;
    logic [mif_pkg::DVS_W-1:0]        w_dvs;
    logic signed [mif_pkg::NUM_W-1:0] w_prod, w_num;
    logic [mif_pkg::DVS_W-1:0]        w_trial;
    logic                             w_ge;
    logic [mif_pkg::MAG_W-1:0]        w_res;
    logic signed [mif_pkg::HIST_W-1:0] w_hist;
    logic                             w_valid_res;

    // operand select for the average being updated
    always_comb begin
        case (i_cmd.op)
            mif_pkg::OP_FAST: begin
                w_old = $signed({1'b0, r_ema_fast});
                w_x   = $signed({1'b0, r_price});
                w_per = r_fast_per;
            end
            mif_pkg::OP_SLOW: begin
                w_old = $signed({1'b0, r_ema_slow});
                w_x   = $signed({1'b0, r_price});
                w_per = r_slow_per;
            end
            default: begin
                w_old = r_ema_sig;
                w_x   = r_dif;
                w_per = r_sig_per;
            end
        endcase
    end

    // old*(n-1) + 2*x, divisor n+1
    assign w_pe   = mif_pkg::eff_period(w_per);
    assign w_nm1  = w_pe - 1'b1;
    assign w_dvs  = {1'b0, w_pe} + 1'b1;
    assign w_prod = w_old * $signed({1'b0, w_nm1});
    assign w_num  = w_prod + (mif_pkg::NUM_W'(w_x) <<< 1);

    // one restoring divide step
    assign w_trial = {r_rem, r_quo[mif_pkg::MAG_W-1]};
    assign w_ge    = (w_trial >= w_dvs);

    // quotient rounded toward zero
    assign w_res = r_neg ? (~r_quo + 1'b1) : r_quo;

    // output fields
    assign w_hist = (mif_pkg::HIST_W'(r_dif) - mif_pkg::HIST_W'(r_ema_sig)) <<< 1;
    assign w_valid_res = (r_count >= mif_pkg::eff_period(r_fast_per)) &&
                         (r_count >= mif_pkg::eff_period(r_slow_per)) &&
                         (r_count >= mif_pkg::eff_period(r_sig_per));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_per <= mif_pkg::FAST_PERIOD_RST;
            r_slow_per <= mif_pkg::SLOW_PERIOD_RST;
            r_sig_per  <= mif_pkg::SIGNAL_PERIOD_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                mif_pkg::CFG_FAST_PERIOD:   r_fast_per <= i_cfg_data;
                mif_pkg::CFG_SLOW_PERIOD:   r_slow_per <= i_cfg_data;
                mif_pkg::CFG_SIGNAL_PERIOD: r_sig_per  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // series state: seeding or counting on accept, write back after each divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_fast <= '0;
            r_ema_slow <= '0;
            r_ema_sig  <= '0;
            r_dif      <= '0;
            r_count    <= '0;
            r_restart  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_restart <= i_restart;
            if (i_restart) begin
                r_ema_fast <= i_price;
                r_ema_slow <= i_price;
                r_ema_sig  <= '0;
                r_dif      <= '0;
                r_count    <= mif_pkg::CNT_W'(1);
            end else if (r_count != mif_pkg::CNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end else if (i_cmd.wb) begin
            case (i_cmd.op)
                mif_pkg::OP_FAST: begin
                    r_ema_fast <= w_res[mif_pkg::PRICE_W-1:0];
                end
                mif_pkg::OP_SLOW: begin
                    r_ema_slow <= w_res[mif_pkg::PRICE_W-1:0];
                    r_dif      <= $signed({1'b0, r_ema_fast}) -
                                  $signed({1'b0, w_res[mif_pkg::PRICE_W-1:0]});
                end
                default: begin
                    r_ema_sig <= $signed(w_res[mif_pkg::SIG_W-1:0]);
                end
            endcase
        end
    end

    // input price, multiply-add and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_price <= i_price;
        end
        if (i_cmd.mul) begin
            r_num <= w_num;
        end
        if (i_cmd.load) begin
            r_neg <= r_num[mif_pkg::NUM_W-1];
            r_rem <= '0;
            r_quo <= r_num[mif_pkg::NUM_W-1] ? mif_pkg::MAG_W'(-r_num)
                                             : r_num[mif_pkg::MAG_W-1:0];
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? mif_pkg::PER_W'(w_trial - w_dvs) : w_trial[mif_pkg::PER_W-1:0];
            r_quo <= {r_quo[mif_pkg::MAG_W-2:0], w_ge};
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {3'b000, w_hist, r_ema_sig, r_dif, r_ema_slow, r_ema_fast};
            r_m_user <= w_valid_res;
        end
    end

    assign o_sts.restart  = r_restart;
    assign o_sts.out_busy = r_m_valid & ~i_m_ready;
    assign o_m_valid      = r_m_valid;
    assign o_m_data       = r_m_data;
    assign o_m_user       = r_m_user;

endmodule

### sv/macd_indicator_filter_core.sv
// ----------------------------------------------------------------------------
// macd_indicator_filter_core
// macd indicator over a price stream: fast, slow and signal averages
// ----------------------------------------------------------------------------
// One price sample in on the s_axis channel (tdata: unsigned Q16.16 price,
// tuser: restart flag), one result out on the m_axis channel for every sample.
// Periods must be written on the cfg channel (index 0 fast, 1 slow, 2 signal)
// only while no sample is in flight (not enforced); cfg_ready is always high.
// A restart sample seeds both averages with the price and the signal average
// with zero; it skips the divider and its result goes to the output register.
// Any other sample updates the three averages one after another through one
// multiply-add and one restoring divider that retires one quotient bit per
// cycle; each average runs through multiply, load, divide and write-back.
// One sample is in the block at a time; s_axis_tready is high only while it
// is idle, so a new sample is taken only once the last one has left the sequencer.
// The result sits in an output register; the next sample is taken while it
// waits, and a stalled receiver holds the following result back in the
// sequencer until the register frees up.
// Reset restores periods 12/26/9 and clears the averages and sample count.
// ----------------------------------------------------------------------------
`include "macd_indicator_filter_core_defines.svh"

module macd_indicator_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] price
    input  logic [mif_pkg::PRICE_W-1:0]         s_axis_tdata,
    // [0] restart
    input  logic                                s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] ema_fast_out, [63:32] ema_slow_out, [96:64] dif_out,
    // [129:97] dea_out, [164:130] histogram, [167:165] zero
    output logic [mif_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] valid_res
    output logic                                m_axis_tuser,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mif_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mif_pkg::PER_W-1:0]           i_cfg_data
);

    mif_pkg::t_cmd w_cmd;
    mif_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mif_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // arithmetic and state
    mif_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_wr    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_price     (s_axis_tdata),
        .i_restart   (s_axis_tuser),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser)
    );

    // checks
    `MIF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sample accepted while another is in flight")
    `MIF_ASSERT_SAME(a_dif_matches, i_clk, i_rst_n, m_axis_tvalid, (33'(m_axis_tdata[31:0]) - 33'(m_axis_tdata[63:32])) == m_axis_tdata[96:64], "dif is not fast minus slow")
    `MIF_ASSERT_SAME(a_hist_matches, i_clk, i_rst_n, m_axis_tvalid, ((35'($signed(m_axis_tdata[96:64])) - 35'($signed(m_axis_tdata[129:97]))) << 1) == m_axis_tdata[164:130], "histogram is not twice dif minus dea")

endmodule
